@@ design/fwm_pkg.sv @@
// Package for the frame window multiplier: widths, codes and the CORDIC arctangent table.
package fwm_pkg;

    localparam int DEF_MAX_FRAME      = 4096;
    localparam int DEF_SAMPLE_BITS    = 16;
    localparam int DEF_COEF_FRAC_BITS = 15;

    localparam int PHASE_BITS   = 20;              // phase as a fraction of one turn
    localparam int DIV_STEPS    = PHASE_BITS + 1;  // quotient bits produced by the divider
    localparam int CORDIC_STEPS = 18;
    localparam int STEP_CNT_W   = 5;

    localparam int XY_W     = 33;   // CORDIC x/y, Q2.30 with headroom
    localparam int Z_W      = 21;   // residual angle in 2^-20 turns
    localparam int CV_W     = 34;   // quadrant-mapped cosine
    localparam int HAMM_B_W = 20;
    localparam int C30_W    = 36;   // coefficient in Q30 before rounding
    localparam int EPOCH_W  = 4;

    localparam logic signed [XY_W-1:0]     CORDIC_GAIN = 33'sd652032874;
    localparam logic signed [C30_W-1:0]    ONE_Q30     = 36'sd1073741824;
    localparam logic signed [C30_W-1:0]    HAMM_OFFSET = 36'sd579820585;  // 0.54 in Q30
    localparam logic signed [HAMM_B_W-1:0] HAMM_SLOPE  = 20'sd482345;     // 0.46 in Q20

    localparam int TYPE_W      = 2;
    localparam int FRAME_LEN_W = 13;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [FRAME_LEN_W-1:0] FRAME_LEN_RESET = 13'd4096;

    typedef enum logic [TYPE_W-1:0] {
        WIN_RECT    = 2'd0,
        WIN_HANN    = 2'd1,
        WIN_HAMMING = 2'd2,
        WIN_ZERO    = 2'd3
    } win_kind_t;

    typedef enum logic {
        REG_WINDOW_TYPE  = 1'b0,
        REG_FRAME_LENGTH = 1'b1
    } reg_index_t;

    // arctan(2^-k) in 2^-20 turns
    function automatic logic signed [Z_W-1:0] cordic_atan(input logic [STEP_CNT_W-1:0] k);
        logic signed [Z_W-1:0] a;
        case (k)
            5'd0:    a = 21'sd131072;
            5'd1:    a = 21'sd77376;
            5'd2:    a = 21'sd40884;
            5'd3:    a = 21'sd20753;
            5'd4:    a = 21'sd10417;
            5'd5:    a = 21'sd5213;
            5'd6:    a = 21'sd2607;
            5'd7:    a = 21'sd1304;
            5'd8:    a = 21'sd652;
            5'd9:    a = 21'sd326;
            5'd10:   a = 21'sd163;
            5'd11:   a = 21'sd81;
            5'd12:   a = 21'sd41;
            5'd13:   a = 21'sd20;
            5'd14:   a = 21'sd10;
            5'd15:   a = 21'sd5;
            5'd16:   a = 21'sd3;
            5'd17:   a = 21'sd1;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

@@ design/fwm_ram.sv @@
// Simple dual-port RAM: one write port, one read port with registered read data.
module fwm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ design/frame_window_multiplier.sv @@
// Frame window multiplier: Hann/Hamming/rectangular window over a sample stream.
//
//  channel  dir  handshake                  payload
//  s_       in   s_tvalid / s_tready        s_tdata: sample_in
//  m_       out  m_tvalid / m_tready        m_tdata: windowed_out, m_tlast: frame_end
//  apb      in   psel / penable / pready    window_type @0x0, frame_length @0x4
//
// One item at a time. Coefficients are cached per frame position in a RAM tagged with
// an epoch that moves on every register write. Rectangular, zero window or a cache hit:
// states idle, lookup, multiply, output. A miss runs the 21-step phase divider and 18-step
// CORDIC. After reset and on every 16th register write, a clearing pass sweeps all MAX_FRAME
// cache entries with s_tready low. The next sample is taken while m_ holds a result.
module frame_window_multiplier #(
    parameter int MAX_FRAME      = fwm_pkg::DEF_MAX_FRAME,
    parameter int SAMPLE_BITS    = fwm_pkg::DEF_SAMPLE_BITS,
    parameter int COEF_FRAC_BITS = fwm_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,   // sample_in
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]     m_tdata,   // windowed_out
    output logic                                 m_tlast,   // frame_end
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [fwm_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [fwm_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [fwm_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                 pready
);

    import fwm_pkg::*;

    localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int POS_W   = $clog2(MAX_FRAME);
    localparam int LEN_W   = $clog2(MAX_FRAME + 1);
    localparam int CMP_W   = (LEN_W > FRAME_LEN_W) ? LEN_W : FRAME_LEN_W;
    localparam int COEF_W  = COEF_FRAC_BITS + 1;
    localparam int PROD_W  = SAMPLE_BITS + COEF_W + 1;
    localparam int RAM_W   = 1 + EPOCH_W + COEF_W;
    localparam int NUM_W   = POS_W + PHASE_BITS + 1;
    localparam int HP_W    = CV_W + HAMM_B_W;

    localparam logic [COEF_W-1:0] UNITY = {1'b1, {COEF_FRAC_BITS{1'b0}}};
    localparam logic signed [C30_W-1:0] UNITY_Q = C30_W'(longint'(1) << COEF_FRAC_BITS);
    localparam logic signed [PROD_W-1:0] RND_HALF =
        PROD_W'(longint'(1) << (COEF_FRAC_BITS - 1));
    localparam logic signed [PROD_W-1:0] SMAX =
        PROD_W'((longint'(1) << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [PROD_W-1:0] SMIN = ~SMAX;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LOOKUP, ST_DIV, ST_CORDIC, ST_COS, ST_HAMM, ST_COEF, ST_MULT, ST_OUT
    } state_t;

    state_t                   state_reg;
    win_kind_t                win_type_reg;
    logic [FRAME_LEN_W-1:0]   frame_len_reg;
    logic [EPOCH_W-1:0]       epoch_reg;
    logic                     clr_active_reg;
    logic [POS_W-1:0]         clr_addr_reg;
    logic [POS_W-1:0]         pos_reg;

    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic [POS_W-1:0]         idx_reg;
    logic [POS_W-1:0]         span_reg;
    logic                     last_reg;
    win_kind_t                kind_reg;

    logic [POS_W-1:0]         rem_reg;
    logic [PHASE_BITS:0]      dlow_reg;
    logic [PHASE_BITS-1:0]    quot_reg;
    logic [STEP_CNT_W-1:0]    cnt_reg;
    logic [1:0]               quad_reg;
    logic signed [XY_W-1:0]   x_reg;
    logic signed [XY_W-1:0]   y_reg;
    logic signed [Z_W-1:0]    z_reg;
    logic signed [CV_W-1:0]   cv_reg;
    logic signed [HP_W-1:0]   hp_reg;
    logic [COEF_W-1:0]        coef_reg;
    logic signed [PROD_W-1:0] prod_reg;

    logic                     m_tvalid_reg;
    logic [SAMPLE_BITS-1:0]   wout_reg;
    logic                     tlast_reg;

    // ---------------- configuration ----------------
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_type_reg  <= WIN_RECT;
            frame_len_reg <= FRAME_LEN_RESET;
        end else if (cfg_wr) begin
            case (reg_index_t'(paddr[2]))
                REG_WINDOW_TYPE:  win_type_reg  <= win_kind_t'(pwdata[TYPE_W-1:0]);
                REG_FRAME_LENGTH: frame_len_reg <= pwdata[FRAME_LEN_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb begin
        case (reg_index_t'(paddr[2]))
            REG_WINDOW_TYPE:  prdata = APB_DATA_W'(win_type_reg);
            REG_FRAME_LENGTH: prdata = APB_DATA_W'(frame_len_reg);
            default:          prdata = '0;
        endcase
    end

    // Cache epoch; a wrap of the epoch forces a full clearing sweep
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            epoch_reg      <= '0;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end else begin
            if (cfg_wr && (epoch_reg == {EPOCH_W{1'b1}})) begin
                clr_active_reg <= 1'b1;
                clr_addr_reg   <= '0;
            end else if (clr_active_reg) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == POS_W'(MAX_FRAME - 1)) begin
                    clr_active_reg <= 1'b0;
                end
            end
            if (cfg_wr) begin
                epoch_reg <= epoch_reg + 1'b1;
            end
        end
    end

    // ---------------- frame position ----------------
    logic [CMP_W-1:0] len_ext;
    logic [CMP_W-1:0] eff_len;
    logic [POS_W-1:0] span_now;
    logic             last_now;
    logic [POS_W-1:0] idx_now;
    logic             accept;

    always_comb begin
        len_ext = CMP_W'(frame_len_reg);
        if (len_ext < CMP_W'(2)) begin
            eff_len = CMP_W'(2);
        end else if (len_ext > CMP_W'(MAX_FRAME)) begin
            eff_len = CMP_W'(MAX_FRAME);
        end else begin
            eff_len = len_ext;
        end
        span_now = POS_W'(eff_len - 1'b1);
        last_now = (pos_reg >= span_now);
        idx_now  = last_now ? span_now : pos_reg;
    end

    assign s_tready = (state_reg == ST_IDLE) && !clr_active_reg;
    assign accept   = s_tvalid & s_tready;

    // ---------------- coefficient cache ----------------
    logic               ram_wr_en;
    logic [POS_W-1:0]   ram_wr_addr;
    logic [RAM_W-1:0]   ram_wr_data;
    logic [RAM_W-1:0]   ram_rd_data;
    logic               cache_hit;
    logic [COEF_W-1:0]  coef_calc;

    assign ram_wr_en   = clr_active_reg | (state_reg == ST_COEF);
    assign ram_wr_addr = clr_active_reg ? clr_addr_reg : idx_reg;
    assign ram_wr_data = clr_active_reg ? '0 : {1'b1, epoch_reg, coef_calc};
    assign cache_hit   = ram_rd_data[RAM_W-1] &&
                         (ram_rd_data[RAM_W-2 -: EPOCH_W] == epoch_reg);

    fwm_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_FRAME)
    ) u_coef_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (accept),
        .rd_addr (idx_now),
        .rd_data (ram_rd_data)
    );

    // ---------------- phase divider step ----------------
    logic [NUM_W-1:0]      num_init;
    logic [POS_W:0]        trial;
    logic                  div_ge;
    logic [POS_W-1:0]      rem_step;
    logic [PHASE_BITS-1:0] quot_step;

    always_comb begin
        num_init  = NUM_W'({idx_reg, {PHASE_BITS{1'b0}}}) + NUM_W'(span_reg >> 1);
        trial     = {rem_reg, dlow_reg[PHASE_BITS]};
        div_ge    = (trial >= {1'b0, span_reg});
        rem_step  = div_ge ? POS_W'(trial - {1'b0, span_reg}) : trial[POS_W-1:0];
        quot_step = {quot_reg[PHASE_BITS-2:0], div_ge};
    end

    // ---------------- CORDIC step and cosine mapping ----------------
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic signed [Z_W-1:0]  atan_k;
    logic signed [CV_W-1:0] cv_sel;

    always_comb begin
        dx     = y_reg >>> cnt_reg;
        dy     = x_reg >>> cnt_reg;
        atan_k = cordic_atan(cnt_reg);
        case (quad_reg)
            2'd0:    cv_sel = CV_W'(x_reg);
            2'd1:    cv_sel = -CV_W'(y_reg);
            2'd2:    cv_sel = -CV_W'(x_reg);
            default: cv_sel = CV_W'(y_reg);
        endcase
    end

    // ---------------- coefficient rounding ----------------
    logic signed [C30_W-1:0] c30;
    logic signed [C30_W-1:0] coef_round;

    always_comb begin
        if (kind_reg == WIN_HANN) begin
            c30 = (ONE_Q30 - C30_W'(cv_reg)) >>> 1;
        end else begin
            c30 = HAMM_OFFSET - C30_W'(hp_reg >>> 20);
        end
        coef_round = (c30 + (ONE_Q30 >>> (COEF_FRAC_BITS + 1))) >>> (30 - COEF_FRAC_BITS);
        if (coef_round[C30_W-1]) begin
            coef_calc = '0;
        end else if (coef_round > UNITY_Q) begin
            coef_calc = UNITY;
        end else begin
            coef_calc = COEF_W'(coef_round);
        end
    end

    // ---------------- output rounding and saturation ----------------
    logic signed [PROD_W-1:0] prod_rnd;
    logic [SAMPLE_BITS-1:0]   sat_val;

    always_comb begin
        prod_rnd = (prod_reg + RND_HALF) >>> COEF_FRAC_BITS;
        if (prod_rnd > SMAX) begin
            sat_val = SMAX[SAMPLE_BITS-1:0];
        end else if (prod_rnd < SMIN) begin
            sat_val = SMIN[SAMPLE_BITS-1:0];
        end else begin
            sat_val = prod_rnd[SAMPLE_BITS-1:0];
        end
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pos_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            cnt_reg      <= '0;
        end else begin
            // ST_OUT decides m_tvalid itself
            if (m_tvalid_reg && m_tready && (state_reg != ST_OUT)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        sample_reg <= $signed(s_tdata[SAMPLE_BITS-1:0]);
                        idx_reg    <= idx_now;
                        span_reg   <= span_now;
                        last_reg   <= last_now;
                        kind_reg   <= win_type_reg;
                        pos_reg    <= last_now ? '0 : idx_now + 1'b1;
                        state_reg  <= ST_LOOKUP;
                    end
                end
                ST_LOOKUP: begin
                    case (kind_reg)
                        WIN_RECT: begin
                            coef_reg  <= UNITY;
                            state_reg <= ST_MULT;
                        end
                        WIN_ZERO: begin
                            coef_reg  <= '0;
                            state_reg <= ST_MULT;
                        end
                        default: begin
                            if (cache_hit) begin
                                coef_reg  <= ram_rd_data[COEF_W-1:0];
                                state_reg <= ST_MULT;
                            end else begin
                                rem_reg   <= num_init[NUM_W-1 -: POS_W];
                                dlow_reg  <= num_init[PHASE_BITS:0];
                                quot_reg  <= '0;
                                cnt_reg   <= '0;
                                state_reg <= ST_DIV;
                            end
                        end
                    endcase
                end
                ST_DIV: begin
                    rem_reg  <= rem_step;
                    dlow_reg <= {dlow_reg[PHASE_BITS-1:0], 1'b0};
                    quot_reg <= quot_step;
                    if (cnt_reg == STEP_CNT_W'(DIV_STEPS - 1)) begin
                        // phase complete: split into quadrant and first-quadrant angle
                        quad_reg  <= quot_step[PHASE_BITS-1 -: 2];
                        x_reg     <= CORDIC_GAIN;
                        y_reg     <= '0;
                        z_reg     <= Z_W'(quot_step[PHASE_BITS-3:0]);
                        cnt_reg   <= '0;
                        state_reg <= ST_CORDIC;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_CORDIC: begin
                    if (!z_reg[Z_W-1]) begin
                        x_reg <= x_reg - dx;
                        y_reg <= y_reg + dy;
                        z_reg <= z_reg - atan_k;
                    end else begin
                        x_reg <= x_reg + dx;
                        y_reg <= y_reg - dy;
                        z_reg <= z_reg + atan_k;
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == STEP_CNT_W'(CORDIC_STEPS - 1)) begin
                        state_reg <= ST_COS;
                    end
                end
                ST_COS: begin
                    cv_reg    <= cv_sel;
                    state_reg <= ST_HAMM;
                end
                ST_HAMM: begin
                    hp_reg    <= HP_W'(cv_reg) * HP_W'(HAMM_SLOPE);
                    state_reg <= ST_COEF;
                end
                ST_COEF: begin
                    // cache write happens in this cycle unless a clearing pass owns the write port
                    coef_reg  <= coef_calc;
                    state_reg <= ST_MULT;
                end
                ST_MULT: begin
                    prod_reg  <= PROD_W'(sample_reg) * PROD_W'($signed({1'b0, coef_reg}));
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        wout_reg     <= sat_val;
                        tlast_reg    <= last_reg;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = TDATA_W'(wout_reg);
    assign m_tlast  = tlast_reg;

endmodule
